[src/assert_macros.svh]
// Assertion helper macros shared by the RTL files of the annealing schedule block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define GAS_ASSERT_IMPLY(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");
// Next-cycle implication, checked outside reset.
`define GAS_ASSERT_NEXT(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");
`else
`define GAS_ASSERT_IMPLY(name, ck, rn, ante, cons)
`define GAS_ASSERT_NEXT(name, ck, rn, ante, cons)
`endif

`endif

[src/gas_pkg.sv]
// Types, constants and the 2^(2^-k) constant table of the annealing schedule block.
`timescale 1ns / 1ps

package gas_pkg;

  // Field widths of the streams and registers.
  localparam int OP_W       = 2;
  localparam int TP_W       = 24;
  localparam int LOG2_W     = 32;
  localparam int NTP_W      = 24;
  localparam int TEMP_W     = 32;
  localparam int CNT_OUT_W  = 24;
  localparam int OUT_DATA_W = TEMP_W + CNT_OUT_W;
  localparam int CFG_IDX_W  = 2;

  // Interpolation datapath: |d| * idx, then a 33-bit quotient.
  localparam int DMAG_W    = LOG2_W + 1;
  localparam int PROD_W    = DMAG_W + TP_W;
  localparam int Q_W       = PROD_W - TP_W;
  localparam int MUL_STEPS = TP_W;
  localparam int DIV_STEPS = Q_W;
  localparam int STEP_W    = 6;

  // Exponent unit: Q62 mantissa, 16-bit digits of the table constants.
  localparam int FRAC_BITS  = 27;
  localparam int IP_W       = LOG2_W - FRAC_BITS;
  localparam int K_W        = 5;
  localparam int MANT_W     = 64;
  localparam int DIGIT_W    = 16;
  localparam int NUM_DIGITS = MANT_W / DIGIT_W;
  localparam int DIG_IDX_W  = 2;
  localparam int MAC_W      = MANT_W + DIGIT_W;
  localparam int MANT_FRAC  = 62;
  localparam int ROUND_BASE = 30;
  localparam int ROUND_W    = MANT_W - ROUND_BASE;
  localparam logic [IP_W-1:0] SHIFT_BIAS = IP_W'(15);

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_LOG2_INIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG2_FINAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_TP     = 2'd2;

  // Register values after reset: log2(100), log2(0.3), 1000 points.
  localparam logic [LOG2_W-1:0] LOG2_INIT_RST  = 32'sd891723258;
  localparam logic [LOG2_W-1:0] LOG2_FINAL_RST = -32'sd233131630;
  localparam logic [NTP_W-1:0]  NTP_RST        = 24'd1000;

  // Operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_ADVANCE = 2'd0,
    OP_QUERY   = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NONE    = 2'd3
  } gas_op_t;

  // Request and response between the sequencer and the exponent unit.
  typedef struct packed {
    logic              start;
    logic [LOG2_W-1:0] e;
  } gas_exp_req_t;

  typedef struct packed {
    logic              done;
    logic [TEMP_W-1:0] temp;
  } gas_exp_rsp_t;

  typedef logic [FRAC_BITS:0][MANT_W-1:0] pow_tab_t;

  // floor(sqrt(r * 2^62)), one result bit per iteration.
  function automatic logic [MANT_W-1:0] sqrt_q62(input logic [MANT_W-1:0] r);
    logic [2*MANT_W-1:0] tgt;
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W-1:0]   y;
    logic [MANT_W-1:0]   c;
    tgt = {2'b00, r, 62'd0};
    y   = '0;
    for (int b = MANT_FRAC; b >= 0; b--) begin
      c  = y | (64'd1 << b);
      sq = {64'd0, c} * {64'd0, c};
      if (sq <= tgt) begin
        y = c;
      end
    end
    return y;
  endfunction

  // Entry k holds 2^(2^-k) in Q62, each entry the root of the one before.
  function automatic pow_tab_t build_pow_tab();
    pow_tab_t t;
    t[0] = 64'h8000_0000_0000_0000;
    for (int k = 1; k <= FRAC_BITS; k++) begin
      t[k] = sqrt_q62(t[k-1]);
    end
    return t;
  endfunction

  localparam pow_tab_t POW_TAB = build_pow_tab();

endpackage

[src/gas_exp2.sv]
// Exponent unit: 2^(e/2^27) in unsigned Q16.16 with a digit-serial mantissa multiplier.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gas_exp2 (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gas_pkg::gas_exp_req_t req,
  output gas_pkg::gas_exp_rsp_t rsp
);
  import gas_pkg::*;

  typedef enum logic [1:0] {
    E_IDLE,
    E_BIT,
    E_MUL,
    E_ROUND
  } estate_t;

  estate_t               state_r,  state_nxt;
  logic [MANT_W-1:0]     m_r,      m_nxt;
  logic [MANT_W-1:0]     acc_r,    acc_nxt;
  logic [FRAC_BITS-1:0]  fr_r,     fr_nxt;
  logic [K_W-1:0]        k_r,      k_nxt;
  logic [DIG_IDX_W-1:0]  j_r,      j_nxt;
  logic [IP_W-1:0]       s_r,      s_nxt;
  logic                  done_r,   done_nxt;
  logic [TEMP_W-1:0]     temp_r,   temp_nxt;

  logic [MANT_W-1:0]     pow_word;
  logic [DIGIT_W-1:0]    dig;
  logic [MAC_W-1:0]      mprod;
  logic [MAC_W-1:0]      mac;
  logic [ROUND_W-1:0]    y;
  logic [ROUND_W-1:0]    rnd;

  // One 64x16 partial product per cycle, accumulated with the previous digit's carry.
  assign pow_word = POW_TAB[k_r];
  assign dig      = pow_word[int'(j_r) * DIGIT_W +: DIGIT_W];
  assign mprod    = m_r * dig;
  assign mac      = {{DIGIT_W{1'b0}}, acc_r} + mprod;

  // Final shift by 45 - ip keeps one extra bit for round half up.
  assign y   = m_r[MANT_W-1:ROUND_BASE] >> s_r;
  assign rnd = y + ROUND_W'(1);

  always_comb begin
    state_nxt = state_r;
    m_nxt     = m_r;
    acc_nxt   = acc_r;
    fr_nxt    = fr_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    s_nxt     = s_r;
    done_nxt  = 1'b0;
    temp_nxt  = temp_r;
    unique case (state_r)
      E_IDLE: begin
        if (req.start) begin
          m_nxt     = MANT_W'(1) << MANT_FRAC;
          fr_nxt    = req.e[FRAC_BITS-1:0];
          s_nxt     = SHIFT_BIAS - req.e[LOG2_W-1:FRAC_BITS];
          k_nxt     = K_W'(1);
          state_nxt = E_BIT;
        end
      end
      E_BIT: begin
        // A set fraction bit multiplies in its table constant; a clear one is skipped.
        if (fr_r[FRAC_BITS-1]) begin
          j_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = E_MUL;
        end else begin
          fr_nxt = fr_r << 1;
          if (k_r == K_W'(FRAC_BITS)) begin
            state_nxt = E_ROUND;
          end else begin
            k_nxt = k_r + K_W'(1);
          end
        end
      end
      E_MUL: begin
        if (j_r == DIG_IDX_W'(NUM_DIGITS - 1)) begin
          // Product bits 62 and up form the new mantissa.
          m_nxt  = mac[MANT_FRAC-3*DIGIT_W +: MANT_W];
          fr_nxt = fr_r << 1;
          if (k_r == K_W'(FRAC_BITS)) begin
            state_nxt = E_ROUND;
          end else begin
            k_nxt     = k_r + K_W'(1);
            state_nxt = E_BIT;
          end
        end else begin
          acc_nxt = mac[MAC_W-1:DIGIT_W];
          j_nxt   = j_r + DIG_IDX_W'(1);
        end
      end
      E_ROUND: begin
        temp_nxt  = rnd[ROUND_W-1] ? '1 : rnd[TEMP_W:1];
        done_nxt  = 1'b1;
        state_nxt = E_IDLE;
      end
      default: state_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    m_r    <= m_nxt;
    acc_r  <= acc_nxt;
    fr_r   <= fr_nxt;
    k_r    <= k_nxt;
    j_r    <= j_nxt;
    s_r    <= s_nxt;
    temp_r <= temp_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.temp = temp_r;

  // The mantissa stays in [1, 2) while a conversion runs.
  `GAS_ASSERT_IMPLY(a_mant_norm, clk, rst_n, state_r != E_IDLE, m_r[MANT_W-1:MANT_W-2] == 2'b01)
  // A start is only issued to an idle unit.
  `GAS_ASSERT_IMPLY(a_start_idle, clk, rst_n, req.start, state_r == E_IDLE)
  // Completion is a single-cycle pulse.
  `GAS_ASSERT_NEXT(a_done_pulse, clk, rst_n, done_r, !done_r)

endmodule

[src/geometric_annealing_schedule.sv]
// Top level: log-linear annealing temperature generator with serial interpolation.
// Interpolated points run the 24-step multiply, the 33-step divider and then the exponent unit,
// whose 64x16 digit multiplier runs once per set bit of the 27-bit exponent fraction; at or past
// the end or for a one-point schedule only the exponent unit runs; clear and unused ops skip all
// three. A new item is taken only when idle, once the previous output word has been loaded.
// Synchronous reset clears the call counter and loads log2(100), log2(0.3) and 1000 points.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module geometric_annealing_schedule #(
  parameter int COUNT_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [gas_pkg::TP_W-1:0]        in_tdata,   // [23:0] time_point
  input  logic [gas_pkg::OP_W-1:0]        in_tuser,   // [1:0] op
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [gas_pkg::OUT_DATA_W-1:0]  out_tdata,  // [31:0] temperature_out, [55:32] count_out
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gas_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gas_pkg::LOG2_W-1:0]      cfg_data
);
  import gas_pkg::*;

  localparam int CW = (COUNT_BITS > TP_W) ? COUNT_BITS : TP_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_MUL,
    S_BIAS,
    S_DIV,
    S_SIGN,
    S_EXP,
    S_WAIT,
    S_OUT
  } state_t;

  // Configuration registers.
  logic [LOG2_W-1:0]     log2_init_r;
  logic [LOG2_W-1:0]     log2_final_r;
  logic [NTP_W-1:0]      ntp_r;

  state_t                state_r,      state_nxt;
  gas_op_t               op_r,         op_nxt;
  logic [TP_W-1:0]       tp_r,         tp_nxt;
  logic [COUNT_BITS-1:0] counter_r,    counter_nxt;
  logic [NTP_W-1:0]      den_r,        den_nxt;
  logic [DMAG_W-1:0]     dmag_r,       dmag_nxt;
  logic                  neg_r,        neg_nxt;
  logic [TP_W-1:0]       mul_b_r,      mul_b_nxt;
  logic [PROD_W-1:0]     w_r,          w_nxt;
  logic [STEP_W-1:0]     step_r,       step_nxt;
  logic [LOG2_W-1:0]     e_r,          e_nxt;
  logic [TEMP_W-1:0]     temp_r,       temp_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r,  out_tdata_nxt;

  logic [CW-1:0]         cnt_ext;
  logic [CW-1:0]         idx_ext;
  logic [CW-1:0]         tp_ext;
  logic [CW-1:0]         ntp_ext;
  logic                  past_end;
  logic [TP_W-1:0]       idx24;
  logic [DMAG_W-1:0]     d_full;
  logic [TP_W:0]         div_try;
  logic [TP_W:0]         div_rem;
  logic                  div_bit;
  logic [LOG2_W+1:0]     e_wide;

  gas_exp_req_t          exp_req;
  gas_exp_rsp_t          exp_rsp;

  gas_exp2 u_exp2 (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (exp_req),
    .rsp   (exp_rsp)
  );

  assign exp_req.start = (state_r == S_EXP);
  assign exp_req.e     = e_r;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Register writes; the host must write only while the block is idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log2_init_r  <= LOG2_INIT_RST;
      log2_final_r <= LOG2_FINAL_RST;
      ntp_r        <= NTP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LOG2_INIT:  log2_init_r  <= cfg_data;
        CFG_LOG2_FINAL: log2_final_r <= cfg_data;
        CFG_NUM_TP:     ntp_r        <= cfg_data[NTP_W-1:0];
        default: ;
      endcase
    end
  end

  // Index selection and end-of-schedule test.
  assign cnt_ext  = CW'(counter_r);
  assign idx_ext  = cnt_ext - CW'(1);
  assign tp_ext   = CW'(tp_r);
  assign ntp_ext  = CW'(ntp_r);
  assign past_end = (op_r == OP_ADVANCE) ? (cnt_ext >= ntp_ext) : (tp_ext >= ntp_ext);
  assign idx24    = (op_r == OP_ADVANCE) ? idx_ext[TP_W-1:0] : tp_r;
  assign d_full   = {log2_final_r[LOG2_W-1], log2_final_r} - {log2_init_r[LOG2_W-1], log2_init_r};

  // One restoring division step: remainder in the top bits, quotient shifts in below.
  assign div_try = {w_r[PROD_W-1 -: TP_W], w_r[Q_W-1]};
  always_comb begin
    if (div_try >= {1'b0, den_r}) begin
      div_rem = div_try - {1'b0, den_r};
      div_bit = 1'b1;
    end else begin
      div_rem = div_try;
      div_bit = 1'b0;
    end
  end

  // Exponent = initial +/- rounded quotient; it always lies between the two endpoints.
  assign e_wide = neg_r ? ({{2{log2_init_r[LOG2_W-1]}}, log2_init_r} - {1'b0, w_r[Q_W-1:0]})
                        : ({{2{log2_init_r[LOG2_W-1]}}, log2_init_r} + {1'b0, w_r[Q_W-1:0]});

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    tp_nxt         = tp_r;
    counter_nxt    = counter_r;
    den_nxt        = den_r;
    dmag_nxt       = dmag_r;
    neg_nxt        = neg_r;
    mul_b_nxt      = mul_b_r;
    w_nxt          = w_r;
    step_nxt       = step_r;
    e_nxt          = e_r;
    temp_nxt       = temp_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt = gas_op_t'(in_tuser);
          tp_nxt = in_tdata;
          unique case (gas_op_t'(in_tuser))
            OP_ADVANCE: begin
              if (counter_r != '1) begin
                counter_nxt = counter_r + COUNT_BITS'(1);
              end
            end
            OP_CLEAR: counter_nxt = '0;
            default: ;
          endcase
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        if (op_r == OP_CLEAR || op_r == OP_NONE) begin
          temp_nxt  = '0;
          state_nxt = S_OUT;
        end else if (past_end) begin
          e_nxt     = log2_final_r;
          state_nxt = S_EXP;
        end else if (ntp_r == NTP_W'(1)) begin
          e_nxt     = log2_init_r;
          state_nxt = S_EXP;
        end else begin
          den_nxt   = ntp_r - NTP_W'(1);
          neg_nxt   = d_full[DMAG_W-1];
          dmag_nxt  = d_full[DMAG_W-1] ? (DMAG_W'(0) - d_full) : d_full;
          mul_b_nxt = idx24;
          w_nxt     = '0;
          step_nxt  = STEP_W'(MUL_STEPS - 1);
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        // Shift-add over the index bits, most significant first.
        w_nxt     = {w_r[PROD_W-2:0], 1'b0} + PROD_W'(mul_b_r[TP_W-1] ? dmag_r : '0);
        mul_b_nxt = mul_b_r << 1;
        if (step_r == '0) begin
          state_nxt = S_BIAS;
        end else begin
          step_nxt = step_r - STEP_W'(1);
        end
      end
      S_BIAS: begin
        // Half the divisor added for round to nearest.
        w_nxt     = w_r + PROD_W'(den_r >> 1);
        step_nxt  = STEP_W'(DIV_STEPS - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        w_nxt = {div_rem[TP_W-1:0], w_r[Q_W-2:0], div_bit};
        if (step_r == '0) begin
          state_nxt = S_SIGN;
        end else begin
          step_nxt = step_r - STEP_W'(1);
        end
      end
      S_SIGN: begin
        e_nxt     = e_wide[LOG2_W-1:0];
        state_nxt = S_EXP;
      end
      S_EXP: state_nxt = S_WAIT;
      S_WAIT: begin
        if (exp_rsp.done) begin
          temp_nxt  = exp_rsp.temp;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // Load the output word once the previous one has been taken.
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {cnt_ext[CNT_OUT_W-1:0], temp_r};
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      counter_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      counter_r    <= counter_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    op_r        <= op_nxt;
    tp_r        <= tp_nxt;
    den_r       <= den_nxt;
    dmag_r      <= dmag_nxt;
    neg_r       <= neg_nxt;
    mul_b_r     <= mul_b_nxt;
    w_r         <= w_nxt;
    step_r      <= step_nxt;
    e_r         <= e_nxt;
    temp_r      <= temp_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  // A clear word leaves the counter at zero.
  `GAS_ASSERT_NEXT(a_cnt_clear, clk, rst_n, in_tvalid && in_tready && in_tuser == OP_CLEAR, counter_r == '0)
  // The partial remainder stays below the divisor throughout the division.
  `GAS_ASSERT_IMPLY(a_div_rem, clk, rst_n, state_r == S_DIV, w_r[PROD_W-1 -: TP_W] < den_r)

endmodule
